/* sv/scalar_kalman_filter_macros.svh */
// Assertion macros shared by the scalar Kalman filter RTL.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SKF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SKF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/skf_pkg.sv */
// Types and constants of the scalar Kalman filter.
`default_nettype none

package skf_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned GAIN_W  = 29;
   localparam int unsigned FRAC_W  = 28;
   localparam int unsigned INDEX_W = 3;
   localparam int unsigned PROD_W  = 45;
   localparam int unsigned ACC_W   = 61;

   localparam logic [GAIN_W-1:0] GAIN_ONE = 29'h1000_0000;

   // Register indexes of the configuration port.
   localparam logic [INDEX_W-1:0] REG_INIT_ESTIMATE   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_INIT_COVARIANCE = 3'd1;
   localparam logic [INDEX_W-1:0] REG_PROCESS_NOISE   = 3'd2;
   localparam logic [INDEX_W-1:0] REG_MEAS_NOISE      = 3'd3;

   // Register reset values.
   localparam logic [DATA_W-1:0] RST_INIT_ESTIMATE   = 32'd13107200;
   localparam logic [DATA_W-1:0] RST_INIT_COVARIANCE = 32'd268435456;
   localparam logic [DATA_W-1:0] RST_PROCESS_NOISE   = 32'd26844;
   localparam logic [DATA_W-1:0] RST_MEAS_NOISE      = 32'd80530637;

   // First (most significant) quotient bit position of the gain division.
   localparam logic [4:0] DIV_FIRST_BIT = 5'd28;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_EST_HI,
      S_EST_LO,
      S_EST_ACC,
      S_EST_FIN,
      S_COV_HI,
      S_COV_LO,
      S_COV_ACC,
      S_COV_FIN
   } state_type;

   typedef struct packed {
      logic div_step;
      logic mul_est;
      logic mul_hi;
      logic acc_load;
      logic acc_add;
      logic est_done;
      logic cov_done;
   } ctl_type;

endpackage

`default_nettype wire

/* sv/scalar_kalman_filter.sv */
// Top level of the scalar Kalman filter: sequencer, shared divider and multiplier.
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  req_measurement, req_restart
//   rsp      out        rsp_valid/rsp_stall  rsp_estimate, rsp_gain
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Each request runs the restoring gain divider (one quotient bit per cycle), then
// two passes (high half, low half, accumulate, finish) through the shared
// 29x16 multiplier before the next request can be accepted.
// The result sits in an output register, so a new request is taken while it
// waits; only the final covariance step holds if that register is still full.
// Reset is synchronous and loads the configuration and filter state defaults.
`default_nettype none

`include "scalar_kalman_filter_macros.svh"

module scalar_kalman_filter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [skf_pkg::DATA_W-1:0]   req_measurement,
   input  wire logic                                req_restart,
   // Result channel.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [skf_pkg::DATA_W-1:0]        rsp_estimate,
   output logic [skf_pkg::GAIN_W-1:0]               rsp_gain,
   // Configuration write channel.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [skf_pkg::INDEX_W-1:0]         csr_index,
   input  wire logic [skf_pkg::DATA_W-1:0]          csr_wdata
);

   // Sequencer.
   skf_pkg::state_type state_ff, state_in;
   skf_pkg::ctl_type   ctl;

   // Configuration registers.
   logic [31:0] init_est_ff, init_cov_ff, proc_noise_ff, meas_noise_ff;

   // Filter state: prior estimate and prior covariance.
   logic [31:0] x_ff, x_in;
   logic [31:0] c_ff, c_in;

   // Divider.
   logic [32:0] den_ff, den_in;
   logic [32:0] rem_ff, rem_in;
   logic [28:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [28:0] gain_ff, gain_in;

   // Innovation as sign and magnitude.
   logic        dneg_ff, dneg_in;
   logic [31:0] dmag_ff, dmag_in;

   // Multiplier and accumulator.
   logic [44:0] prod_ff, prod_in;
   logic [60:0] acc_ff, acc_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_est_ff, rsp_est_in;
   logic [28:0] rsp_gain_ff, rsp_gain_in;

   logic req_accept;
   logic rsp_take;
   logic out_free;

   assign req_stall  = (state_ff != skf_pkg::S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   // The output register can take a new result when empty or being emptied.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_estimate = rsp_est_ff;
   assign rsp_gain     = rsp_gain_ff;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes to indexes beyond the list are dropped.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         init_est_ff   <= skf_pkg::RST_INIT_ESTIMATE;
         init_cov_ff   <= skf_pkg::RST_INIT_COVARIANCE;
         proc_noise_ff <= skf_pkg::RST_PROCESS_NOISE;
         meas_noise_ff <= skf_pkg::RST_MEAS_NOISE;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            skf_pkg::REG_INIT_ESTIMATE:   init_est_ff   <= csr_wdata;
            skf_pkg::REG_INIT_COVARIANCE: init_cov_ff   <= csr_wdata;
            skf_pkg::REG_PROCESS_NOISE:   proc_noise_ff <= csr_wdata;
            skf_pkg::REG_MEAS_NOISE:      meas_noise_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Next state.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skf_pkg::S_IDLE:    if (req_accept) state_in = skf_pkg::S_DIV;
         skf_pkg::S_DIV:     if (cnt_ff == 5'd0) state_in = skf_pkg::S_EST_HI;
         skf_pkg::S_EST_HI:  state_in = skf_pkg::S_EST_LO;
         skf_pkg::S_EST_LO:  state_in = skf_pkg::S_EST_ACC;
         skf_pkg::S_EST_ACC: state_in = skf_pkg::S_EST_FIN;
         skf_pkg::S_EST_FIN: state_in = skf_pkg::S_COV_HI;
         skf_pkg::S_COV_HI:  state_in = skf_pkg::S_COV_LO;
         skf_pkg::S_COV_LO:  state_in = skf_pkg::S_COV_ACC;
         skf_pkg::S_COV_ACC: state_in = skf_pkg::S_COV_FIN;
         skf_pkg::S_COV_FIN: if (out_free) state_in = skf_pkg::S_IDLE;
         default:            state_in = skf_pkg::S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath controls decoded from the state.
   // ---------------------------------------------------------------------
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         skf_pkg::S_IDLE:    ;
         skf_pkg::S_DIV:     ctl.div_step = 1'b1;
         skf_pkg::S_EST_HI: begin
            ctl.mul_est = 1'b1;
            ctl.mul_hi  = 1'b1;
         end
         skf_pkg::S_EST_LO: begin
            ctl.mul_est  = 1'b1;
            ctl.acc_load = 1'b1;
         end
         skf_pkg::S_EST_ACC: ctl.acc_add  = 1'b1;
         skf_pkg::S_EST_FIN: ctl.est_done = 1'b1;
         skf_pkg::S_COV_HI:  ctl.mul_hi   = 1'b1;
         skf_pkg::S_COV_LO:  ctl.acc_load = 1'b1;
         skf_pkg::S_COV_ACC: ctl.acc_add  = 1'b1;
         skf_pkg::S_COV_FIN: ctl.cov_done = out_free;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Request setup. A restart reloads the prior from the configuration
   // before the measurement is filtered against it.
   // ---------------------------------------------------------------------
   logic [31:0] start_x, start_c;
   logic [32:0] diff;

   assign start_x = req_restart ? init_est_ff : x_ff;
   assign start_c = req_restart ? init_cov_ff : c_ff;
   assign diff    = {req_measurement[31], req_measurement} - {start_x[31], start_x};

   // ---------------------------------------------------------------------
   // Restoring divider: gain = floor(C * 2^28 / (C + R)). The remainder
   // starts at C >> 1 and takes in bit 0 of C on the first step, then zeros.
   // A zero denominator never sets a quotient bit, so the gain is zero.
   // ---------------------------------------------------------------------
   logic [33:0] div_shift;
   logic [33:0] div_diff;
   logic        div_ge;

   assign div_shift = {rem_ff, (cnt_ff == skf_pkg::DIV_FIRST_BIT) ? c_ff[0] : 1'b0};
   assign div_diff  = div_shift - {1'b0, den_ff};
   assign div_ge    = (div_shift >= {1'b0, den_ff}) && (den_ff != 33'd0);

   // ---------------------------------------------------------------------
   // Shared 29x16 multiplier. The estimate pass multiplies the gain by the
   // innovation magnitude; the covariance pass multiplies (1 - gain) by C.
   // Each pass forms the high half product first, then the low half.
   // ---------------------------------------------------------------------
   logic [28:0] mul_a;
   logic [15:0] mul_b;

   assign mul_a = ctl.mul_est ? gain_ff : (skf_pkg::GAIN_ONE - gain_ff);
   always_comb begin
      if (ctl.mul_est) begin
         mul_b = ctl.mul_hi ? dmag_ff[31:16] : dmag_ff[15:0];
      end else begin
         mul_b = ctl.mul_hi ? c_ff[31:16] : c_ff[15:0];
      end
   end
   assign prod_in = 45'(mul_a) * 45'(mul_b);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.acc_load) begin
         acc_in = 61'(prod_ff);
      end else if (ctl.acc_add) begin
         acc_in = {acc_ff[44:0], 16'h0000} + 61'(prod_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Estimate update: X + floor(gain * d / 2^28), saturated. A negative
   // innovation rounds its magnitude up so the shift floors toward minus
   // infinity.
   // ---------------------------------------------------------------------
   logic [61:0] est_round;
   logic [33:0] est_step;
   logic [34:0] est_delta;
   logic [35:0] est_sum;
   logic [31:0] est_sat;

   assign est_round = dneg_ff ? ({1'b0, acc_ff} + 62'h0FFF_FFFF) : {1'b0, acc_ff};
   assign est_step  = est_round[61:28];
   assign est_delta = dneg_ff ? (35'd0 - {1'b0, est_step}) : {1'b0, est_step};
   assign est_sum   = {{4{x_ff[31]}}, x_ff} + {est_delta[34], est_delta};

   always_comb begin
      if (est_sum[35:31] == 5'b00000 || est_sum[35:31] == 5'b11111) begin
         est_sat = est_sum[31:0];
      end else if (est_sum[35]) begin
         est_sat = 32'h8000_0000;
      end else begin
         est_sat = 32'h7FFF_FFFF;
      end
   end

   // ---------------------------------------------------------------------
   // Covariance update: floor((1 - gain) * C / 2^28) + Q, saturated.
   // ---------------------------------------------------------------------
   logic [33:0] cov_sum;
   logic [31:0] cov_sat;

   assign cov_sum = {1'b0, acc_ff[60:28]} + {2'b00, proc_noise_ff};
   assign cov_sat = (cov_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : cov_sum[31:0];

   // ---------------------------------------------------------------------
   // Next values of the datapath registers.
   // ---------------------------------------------------------------------
   always_comb begin
      x_in         = x_ff;
      c_in         = c_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      gain_in      = gain_ff;
      dneg_in      = dneg_ff;
      dmag_in      = dmag_ff;
      rsp_est_in   = rsp_est_ff;
      rsp_gain_in  = rsp_gain_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;

      if (req_accept) begin
         x_in    = start_x;
         c_in    = start_c;
         den_in  = {1'b0, start_c} + {1'b0, meas_noise_ff};
         rem_in  = {2'b00, start_c[31:1]};
         cnt_in  = skf_pkg::DIV_FIRST_BIT;
         dneg_in = diff[32];
         dmag_in = diff[32] ? 32'(33'd0 - diff) : diff[31:0];
      end

      if (ctl.div_step) begin
         rem_in = div_ge ? div_diff[32:0] : div_shift[32:0];
         quo_in = {quo_ff[27:0], div_ge};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            gain_in = {quo_ff[27:0], div_ge};
         end
      end

      if (ctl.est_done) begin
         x_in = est_sat;
      end

      if (ctl.cov_done) begin
         c_in         = cov_sat;
         rsp_est_in   = x_ff;
         rsp_gain_in  = gain_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // Control registers and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skf_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         x_ff         <= skf_pkg::RST_INIT_ESTIMATE;
         c_ff         <= skf_pkg::RST_INIT_COVARIANCE;
         cnt_ff       <= 5'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         x_ff         <= x_in;
         c_ff         <= c_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      gain_ff     <= gain_in;
      dneg_ff     <= dneg_in;
      dmag_ff     <= dmag_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_est_ff  <= rsp_est_in;
      rsp_gain_ff <= rsp_gain_in;
   end

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `SKF_ASSERT_NXT(a_accept_starts_div, clock, reset, req_accept,
      state_ff == skf_pkg::S_DIV, "accepted request did not start the divider")

   `SKF_ASSERT_IMP(a_div_rem_bound, clock, reset,
      (state_ff == skf_pkg::S_DIV) && (den_ff != 33'd0), rem_ff < den_ff,
      "divider remainder reached the denominator")

   `SKF_ASSERT_NXT(a_div_ends, clock, reset,
      (state_ff == skf_pkg::S_DIV) && (cnt_ff == 5'd0),
      state_ff == skf_pkg::S_EST_HI, "divider did not hand over to the multiplier")

   `SKF_ASSERT_IMP(a_gain_bound, clock, reset, rsp_valid_ff,
      rsp_gain_ff <= skf_pkg::GAIN_ONE, "result gain above one")

   `SKF_ASSERT_IMP(a_result_source, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == skf_pkg::S_COV_FIN, "result appeared outside the final step")

endmodule

`default_nettype wire

/* test/scalar_kalman_filter_tb.sv */
// Self-checking testbench for the scalar Kalman filter: directed table, then random phases.
`timescale 1ns / 1ps

module scalar_kalman_filter_tb;

   // The settle time adds a margin of quiet cycles before the registers are rewritten.
   localparam int unsigned SETTLE_CYCLES  = 48;
   localparam int unsigned RANDOM_ITEMS   = 1150;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned MAX_REPORTS    = 10;

   // Indexes past the last register; writes to them must be dropped.
   localparam logic [skf_pkg::INDEX_W-1:0] REG_UNMAPPED_LOW  = 3'd4;
   localparam logic [skf_pkg::INDEX_W-1:0] REG_UNMAPPED_HIGH = 3'd7;

   localparam longint unsigned Q28_ONE  = 64'd1 << skf_pkg::FRAC_W;
   localparam longint unsigned COV_MAX  = 64'hFFFF_FFFF;
   localparam longint          EST_MAX  = 64'sd2147483647;
   localparam longint          EST_MIN  = -64'sd2147483648;

   localparam logic signed [skf_pkg::DATA_W-1:0] Z_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [skf_pkg::DATA_W-1:0] Z_MIN = 32'sh8000_0000;

   // One filter output: the new estimate and the gain used to reach it.
   typedef struct packed {
      logic [skf_pkg::DATA_W-1:0] estimate;
      logic [skf_pkg::GAIN_W-1:0] gain;
   } filter_out_type;

   typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_type;

   // One line of the directed table: either a register write or a request.
   // When known is set, the typed expectation replaces the predicted one.
   typedef struct packed {
      row_kind_type                kind;
      logic [skf_pkg::INDEX_W-1:0] index;
      logic [skf_pkg::DATA_W-1:0]  wdata;
      logic [skf_pkg::DATA_W-1:0]  measurement;
      logic                        restart;
      logic                        known;
      filter_out_type              expected;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;

   logic                              req_valid;
   logic                              req_stall;
   logic signed [skf_pkg::DATA_W-1:0] req_measurement;
   logic                              req_restart;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic signed [skf_pkg::DATA_W-1:0] rsp_estimate;
   logic [skf_pkg::GAIN_W-1:0]        rsp_gain;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [skf_pkg::INDEX_W-1:0]       csr_index;
   logic [skf_pkg::DATA_W-1:0]        csr_wdata;

   // Shadow copies of the configuration registers and of the filter state.
   logic signed [skf_pkg::DATA_W-1:0] init_est_reg;
   logic [skf_pkg::DATA_W-1:0]        init_cov_reg;
   logic [skf_pkg::DATA_W-1:0]        q_reg;
   logic [skf_pkg::DATA_W-1:0]        r_reg;
   logic signed [skf_pkg::DATA_W-1:0] est_now;
   logic [skf_pkg::DATA_W-1:0]        cov_now;

   filter_out_type estimate_queue[$];
   stim_row_type   directed_rows[$];
   filter_out_type oldest;

   // Idling switches, changed per phase so that some stretches run flat out.
   bit sender_idles;
   bit receiver_idles;

   int unsigned mismatch_count;
   int unsigned requests_sent;
   int unsigned restarts_sent;
   int unsigned results_seen;
   int unsigned writes_done;
   int unsigned settings_used;
   int unsigned zero_gain_steps;
   int unsigned unity_gain_steps;
   int unsigned saturated_covs;

   scalar_kalman_filter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_measurement (req_measurement),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_estimate    (rsp_estimate),
      .rsp_gain        (rsp_gain),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // One filter step on the shadow state. The gain is the exact floor quotient
   // of C * 2^28 over the 33-bit sum C + R, with zero when that sum is zero.
   // The estimate moves toward the measurement by the gain, using a floor
   // shift on the signed product, and is clamped to 32 bits. The covariance is
   // shrunk by one minus the gain, grown by Q and clamped at all ones.
   function automatic filter_out_type kalman_update(
         input logic signed [skf_pkg::DATA_W-1:0] z, input logic restart);
      longint          x;
      longint          zi;
      longint          nx;
      longint unsigned c;
      longint unsigned den;
      longint unsigned g;
      longint unsigned cov;
      filter_out_type  result;
      if (restart) begin
         est_now = init_est_reg;
         cov_now = init_cov_reg;
      end
      x   = longint'(est_now);
      zi  = longint'(z);
      c   = 64'(cov_now);
      den = c + 64'(r_reg);
      g   = (den == 0) ? 64'd0 : (c << skf_pkg::FRAC_W) / den;
      nx  = x + ((longint'(g) * (zi - x)) >>> skf_pkg::FRAC_W);
      if (nx > EST_MAX) nx = EST_MAX;
      if (nx < EST_MIN) nx = EST_MIN;
      cov = (((Q28_ONE - g) * c) >> skf_pkg::FRAC_W) + 64'(q_reg);
      if (cov > COV_MAX) begin
         cov = COV_MAX;
         saturated_covs++;
      end
      if (g == 0) zero_gain_steps++;
      if (g == Q28_ONE) unity_gain_steps++;
      est_now = nx[skf_pkg::DATA_W-1:0];
      cov_now = cov[skf_pkg::DATA_W-1:0];
      result.estimate = nx[skf_pkg::DATA_W-1:0];
      result.gain     = g[skf_pkg::GAIN_W-1:0];
      return result;
   endfunction

   function automatic void table_write(input logic [skf_pkg::INDEX_W-1:0] idx,
                                       input logic [skf_pkg::DATA_W-1:0] value);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.index = idx;
      row.wdata = value;
      directed_rows.push_back(row);
   endfunction

   function automatic void table_request(input logic [skf_pkg::DATA_W-1:0] z,
                                         input logic restart, input logic known,
                                         input logic [skf_pkg::DATA_W-1:0] est,
                                         input logic [skf_pkg::GAIN_W-1:0] gain);
      stim_row_type row;
      row                   = '0;
      row.kind              = ROW_REQUEST;
      row.measurement       = z;
      row.restart           = restart;
      row.known             = known;
      row.expected.estimate = est;
      row.expected.gain     = gain;
      directed_rows.push_back(row);
   endfunction

   // Noise and covariance values: the bounds, realistic fractions and wild values.
   function automatic logic [skf_pkg::DATA_W-1:0] pick_noise();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom;
         3: return $urandom_range(0, 32'd1048576);
         4: return $urandom_range(32'd2684354, 32'd536870912);
         default: return $urandom_range(32'd250000000, 32'd290000000);
      endcase
   endfunction

   task automatic flag_mismatch(input string what, input filter_out_type want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: %s: expected estimate %0d gain 0x%08h, got estimate %0d gain 0x%08h",
                  $time, what, $signed(want.estimate), want.gain, rsp_estimate, rsp_gain);
      end
   endtask

   // Writes one register through the configuration channel. Called at a falling
   // edge with the request side idle; returns at a falling edge.
   task automatic write_register(input logic [skf_pkg::INDEX_W-1:0] idx,
                                 input logic [skf_pkg::DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      unique case (idx)
         skf_pkg::REG_INIT_ESTIMATE:   init_est_reg = value;
         skf_pkg::REG_INIT_COVARIANCE: init_cov_reg = value;
         skf_pkg::REG_PROCESS_NOISE:   q_reg = value;
         skf_pkg::REG_MEAS_NOISE:      r_reg = value;
         default: ;
      endcase
      writes_done++;
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Presents one request after a random gap and holds it until it is taken.
   // The expectation is computed at the accepting edge, so the shadow state
   // advances in the same order as the block's.
   task automatic send_measurement(input logic signed [skf_pkg::DATA_W-1:0] z,
                                   input logic restart, input logic known,
                                   input filter_out_type typed);
      int unsigned    gap;
      filter_out_type prediction;
      gap = sender_idles ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_measurement <= z;
      req_restart     <= restart;
      do @(posedge clock); while (req_stall !== 1'b0);
      prediction = kalman_update(z, restart);
      estimate_queue.push_back(known ? typed : prediction);
      requests_sent++;
      if (restart) restarts_sent++;
      @(negedge clock);
   endtask

   // Stops sending and waits until every outstanding request has produced its
   // result, then lets the block settle for the time given by settle.
   task automatic drain_results(input int unsigned settle);
      req_valid <= 1'b0;
      @(negedge clock);
      while (estimate_queue.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Result side: while receiver_idles is set, a stall length is drawn for each result. Half
   // of the stalls start at once and may expire while the block is still
   // computing; the other half wait for the result to show up and then hold it,
   // so that the block has to keep it while the next request is underway.
   initial begin : result_sink
      int unsigned hold;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         hold = receiver_idles ? $urandom_range(0, 7) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 1) == 1) begin
               do @(posedge clock); while (rsp_valid !== 1'b1);
               @(negedge clock);
            end
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   // Every accepted result is matched against the oldest outstanding expectation.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         results_seen++;
         if (estimate_queue.size() == 0) begin
            flag_mismatch("result with no request outstanding", '0);
         end else begin
            oldest = estimate_queue.pop_front();
            if (oldest.estimate !== rsp_estimate || oldest.gain !== rsp_gain) begin
               flag_mismatch("wrong estimate or gain", oldest);
            end
         end
      end
   end

   // The run is stopped if no handshake of any kind completes for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
             (csr_valid === 1'b1 && csr_ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding.",
               WATCHDOG_LIMIT, estimate_queue.size());
      $display("** scalar_kalman_filter: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int unsigned                 i;
      int unsigned                 k;
      int unsigned                 phase_len;
      int unsigned                 pause_at;
      int unsigned                 random_sent;
      int                          center;
      int                          amp;
      int                          z_val;
      logic                        restart;
      bit                          pipeline_busy;
      logic [skf_pkg::DATA_W-1:0]  start_est;
      logic [skf_pkg::INDEX_W-1:0] spare_index;

      req_valid       = 1'b0;
      req_measurement = '0;
      req_restart     = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      sender_idles    = 1'b1;
      receiver_idles  = 1'b1;
      init_est_reg    = skf_pkg::RST_INIT_ESTIMATE;
      init_cov_reg    = skf_pkg::RST_INIT_COVARIANCE;
      q_reg           = skf_pkg::RST_PROCESS_NOISE;
      r_reg           = skf_pkg::RST_MEAS_NOISE;
      est_now         = skf_pkg::RST_INIT_ESTIMATE;
      cov_now         = skf_pkg::RST_INIT_COVARIANCE;
      pipeline_busy   = 1'b0;
      random_sent     = 0;

      // Reset values in force: ordinary filtering, the measurement extremes,
      // and a restart that arrives together with a measurement.
      table_request(32'sd0, 1'b0, 1'b0, '0, '0);
      table_request(Z_MAX, 1'b0, 1'b0, '0, '0);
      table_request(Z_MIN, 1'b1, 1'b0, '0, '0);
      table_request(-32'sd1, 1'b0, 1'b0, '0, '0);
      // Zero covariance and zero measurement noise: the denominator is zero,
      // so the gain is zero and the estimate stays where the restart put it.
      table_write(skf_pkg::REG_MEAS_NOISE, '0);
      table_write(skf_pkg::REG_INIT_COVARIANCE, '0);
      table_write(skf_pkg::REG_PROCESS_NOISE, '0);
      table_request(32'sd12345, 1'b1, 1'b1, skf_pkg::RST_INIT_ESTIMATE, '0);
      table_request(Z_MAX, 1'b0, 1'b1, skf_pkg::RST_INIT_ESTIMATE, '0);
      // With Q of one LSB and no measurement noise the gain becomes exactly one
      // after the first step, so the estimate follows the measurement.
      table_write(skf_pkg::REG_PROCESS_NOISE, 32'd1);
      table_write(skf_pkg::REG_INIT_ESTIMATE, Z_MIN);
      table_request(Z_MAX, 1'b1, 1'b1, Z_MIN, '0);
      table_request(Z_MAX, 1'b0, 1'b1, Z_MAX, skf_pkg::GAIN_ONE);
      table_request(Z_MIN, 1'b0, 1'b1, Z_MIN, skf_pkg::GAIN_ONE);
      table_request(32'sd0, 1'b0, 1'b1, '0, skf_pkg::GAIN_ONE);
      // Every register at all ones or the top estimate: the covariance saturates.
      table_write(skf_pkg::REG_INIT_COVARIANCE, '1);
      table_write(skf_pkg::REG_PROCESS_NOISE, '1);
      table_write(skf_pkg::REG_MEAS_NOISE, '1);
      table_write(skf_pkg::REG_INIT_ESTIMATE, Z_MAX);
      table_request(Z_MIN, 1'b1, 1'b0, '0, '0);
      table_request(32'sd0, 1'b0, 1'b0, '0, '0);
      table_request(Z_MAX, 1'b0, 1'b0, '0, '0);
      // Writes to unmapped indexes must not alias onto a real register.
      table_write(REG_UNMAPPED_LOW, '0);
      table_write(REG_UNMAPPED_HIGH, '0);
      table_request(32'sd0, 1'b1, 1'b0, '0, '0);
      table_request(32'sh0000_FFFF, 1'b0, 1'b0, '0, '0);
      // Back to the reset settings, with alternating bit patterns.
      table_write(skf_pkg::REG_INIT_ESTIMATE, skf_pkg::RST_INIT_ESTIMATE);
      table_write(skf_pkg::REG_INIT_COVARIANCE, skf_pkg::RST_INIT_COVARIANCE);
      table_write(skf_pkg::REG_PROCESS_NOISE, skf_pkg::RST_PROCESS_NOISE);
      table_write(skf_pkg::REG_MEAS_NOISE, skf_pkg::RST_MEAS_NOISE);
      table_request(skf_pkg::RST_INIT_ESTIMATE, 1'b1, 1'b0, '0, '0);
      table_request(32'sh5555_5555, 1'b0, 1'b0, '0, '0);
      table_request(32'shAAAA_AAAA, 1'b0, 1'b0, '0, '0);
      table_request(32'shFFFF_0000, 1'b1, 1'b0, '0, '0);
      table_request(32'sh0001_0000, 1'b0, 1'b0, '0, '0);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: registers are only touched once the block is quiet.
      settings_used = 1;
      for (i = 0; i < directed_rows.size(); i++) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            if (pipeline_busy) begin
               drain_results(SETTLE_CYCLES);
               pipeline_busy = 1'b0;
               settings_used++;
            end
            write_register(directed_rows[i].index, directed_rows[i].wdata);
         end else begin
            send_measurement($signed(directed_rows[i].measurement), directed_rows[i].restart,
                             directed_rows[i].known, directed_rows[i].expected);
            pipeline_busy = 1'b1;
         end
      end

      // Random part: each phase picks a fresh configuration, then streams a
      // noisy sensor track around a random level, mixed with wild samples.
      while (random_sent < RANDOM_ITEMS) begin
         drain_results(SETTLE_CYCLES);
         settings_used++;
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0: start_est = $urandom;
            1: start_est = ($urandom_range(0, 1) == 1) ? Z_MAX : Z_MIN;
            default: start_est = $urandom_range(0, 32'd131072000) - 32'd65536000;
         endcase
         write_register(skf_pkg::REG_INIT_ESTIMATE, start_est);
         write_register(skf_pkg::REG_INIT_COVARIANCE, pick_noise());
         write_register(skf_pkg::REG_PROCESS_NOISE, pick_noise());
         write_register(skf_pkg::REG_MEAS_NOISE, pick_noise());
         if ($urandom_range(0, 7) == 0) begin
            spare_index = ($urandom_range(0, 1) == 1) ? REG_UNMAPPED_HIGH : REG_UNMAPPED_LOW;
            write_register(spare_index, $urandom);
         end
         phase_len = $urandom_range(15, 60);
         // At least the first phase pauses in the middle until every result is back.
         pause_at = (settings_used == 7 || $urandom_range(0, 2) == 0) ? phase_len / 2
                                                                      : phase_len;
         center = int'($urandom_range(0, 32'd134217728)) - 67108864;
         amp    = 1 << $urandom_range(4, 22);
         for (k = 0; k < phase_len; k++) begin
            if (k == pause_at) drain_results(0);
            case ($urandom_range(0, 9))
               0: z_val = $urandom;
               1: z_val = ($urandom_range(0, 1) == 1) ? Z_MAX : Z_MIN;
               default: z_val = center + int'($urandom_range(0, 2 * amp)) - amp;
            endcase
            restart = (k == 0) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 19) == 0);
            send_measurement(z_val, restart, 1'b0, '0);
            random_sent++;
         end
      end

      drain_results(SETTLE_CYCLES);

      $display("Covered %0d requests (%0d with restart), %0d results, %0d register writes",
               requests_sent, restarts_sent, results_seen, writes_done);
      $display("over %0d settings; %0d zero-gain, %0d unity-gain, %0d saturated-covariance steps.",
               settings_used, zero_gain_steps, unity_gain_steps, saturated_covs);
      if (mismatch_count == 0) begin
         $display("** scalar_kalman_filter: PASSED **");
      end else begin
         $display("%0d mismatches in total.", mismatch_count);
         $display("** scalar_kalman_filter: FAILED **");
      end
      $finish;
   end

endmodule
